// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by scc_core
// every use expects signals named clock and reset in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ----- rtl/core/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Types, codes and sizing constants of the strongly connected components unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

   // fixed field widths
   localparam int VERTEX_W = 6;
   localparam int COUNT_W  = 7;
   localparam int FUNC_W   = 2;

   // default sizing
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 512;

   // vertex count after reset
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [VERTEX_W-1:0] edge_from;
      logic [VERTEX_W-1:0] edge_to;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [VERTEX_W-1:0] component_index;
      logic                last_of_component;
      logic                last;
   } rsp_type;

   // result handed from the sequencer to the output register
   typedef struct packed {
      logic    push;
      rsp_type result;
   } emit_type;

endpackage

`default_nettype wire

// ----- rtl/core/scc_ram.sv -----
// ----------------------------------------------------------------------------
// scc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/scc_core.sv -----
// ----------------------------------------------------------------------------
// scc_core
// Graph store and two-pass depth-first sequencer with an explicit stack.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_core
   import scc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire req_type            req,
   input  wire logic [COUNT_W-1:0] vertex_count,
   input  wire logic               out_free,
   output logic                    idle,
   output emit_type                emit
);

`include "assert_macros.svh"

   localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int SPW = $clog2(MAX_VERTICES + 1);
   localparam int SEW = VERTEX_W + 2 * EW + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ADD    = 4'd1;
   localparam logic [3:0] S_SCAN1  = 4'd2;
   localparam logic [3:0] S_PUSH   = 4'd3;
   localparam logic [3:0] S_STEP   = 4'd4;
   localparam logic [3:0] S_EDGE   = 4'd5;
   localparam logic [3:0] S_POP    = 4'd6;
   localparam logic [3:0] S_SCAN2  = 4'd7;
   localparam logic [3:0] S_SCAN2R = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic                    pass_ff, pass_in;
   logic [COUNT_W-1:0]      scan_ff, scan_in;
   logic [SPW-1:0]          fin_ff, fin_in;
   logic [SPW-1:0]          sp_ff, sp_in;
   logic [COUNT_W-1:0]      comp_ff, comp_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] fne_ff, fne_in;
   logic [MAX_VERTICES-1:0] rne_ff, rne_in;
   logic [ECW-1:0]          total_ff, total_in;
   logic [VERTEX_W-1:0]     top_v_ff, top_v_in;
   logic [EW-1:0]           top_e_ff, top_e_in;
   logic [EW-1:0]           top_t_ff, top_t_in;
   logic                    top_p_ff, top_p_in;
   logic [VERTEX_W-1:0]     pv_ff, pv_in;
   logic [VERTEX_W-1:0]     add_from_ff, add_from_in;
   logic [VERTEX_W-1:0]     add_to_ff, add_to_in;
   logic                    add_ok_ff, add_ok_in;
   logic                    held_valid_ff, held_valid_in;
   logic [VERTEX_W-1:0]     held_v_ff, held_v_in;
   logic [COUNT_W-1:0]      held_c_ff, held_c_in;

   logic [COUNT_W-1:0]  n_act;
   logic [VERTEX_W-1:0] walk_v;
   logic [EW-1:0]       edge_idx;

   // memory read data
   logic [VERTEX_W-1:0] esrc_rd, etgt_rd, fin_rd, far_rd;
   logic [EW-1:0]       fnext_rd, rnext_rd, fhead_rd, rhead_rd, ftail_rd, rtail_rd;
   logic [EW-1:0]       nxt_rd, head_rd, tail_rd;
   logic [SEW-1:0]      stk_rd, stk_wd;
   logic [MAX_VERTICES-1:0] ne_sel;

   // memory control
   logic           add_wr, fnext_we, rnext_we, fhead_we, rhead_we;
   logic           stk_we, fin_we;
   logic [VAW-1:0] ftail_ra, rtail_ra;
   logic [VAW-1:0] stk_wa, stk_ra, fin_ra;

   // vertex count in use
   assign n_act = (vertex_count > COUNT_W'(MAX_VERTICES)) ?
                  COUNT_W'(MAX_VERTICES) : vertex_count;

   assign edge_idx = total_ff[EW-1:0];

   // direction select by pass
   assign far_rd  = pass_ff ? esrc_rd : etgt_rd;
   assign nxt_rd  = pass_ff ? rnext_rd : fnext_rd;
   assign head_rd = pass_ff ? rhead_rd : fhead_rd;
   assign tail_rd = pass_ff ? rtail_rd : ftail_rd;
   assign ne_sel  = pass_ff ? rne_ff : fne_ff;

   // vertex whose list head and tail are fetched
   always_comb begin
      case (state_ff)
         S_SCAN1:  walk_v = scan_ff[VERTEX_W-1:0];
         S_SCAN2R: walk_v = fin_rd;
         S_EDGE:   walk_v = far_rd;
         default:  walk_v = pv_ff;
      endcase
   end

   assign ftail_ra = (state_ff == S_IDLE) ? req.edge_from[VAW-1:0] : walk_v[VAW-1:0];
   assign rtail_ra = (state_ff == S_IDLE) ? req.edge_to[VAW-1:0] : walk_v[VAW-1:0];

   // edge append writes
   assign add_wr   = (state_ff == S_ADD) && add_ok_ff;
   assign fnext_we = add_wr && fne_ff[add_from_ff[VAW-1:0]];
   assign rnext_we = add_wr && rne_ff[add_to_ff[VAW-1:0]];
   assign fhead_we = add_wr && !fne_ff[add_from_ff[VAW-1:0]];
   assign rhead_we = add_wr && !rne_ff[add_to_ff[VAW-1:0]];

   // stack and finish order addressing
   assign stk_wd = {top_v_ff, top_e_ff, top_t_ff, top_p_ff};
   assign stk_wa = VAW'(sp_ff - SPW'(1));
   assign stk_ra = VAW'(sp_ff - SPW'(2));
   assign fin_ra = VAW'(scan_ff - COUNT_W'(1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      scan_in       = scan_ff;
      fin_in        = fin_ff;
      sp_in         = sp_ff;
      comp_in       = comp_ff;
      visited_in    = visited_ff;
      fne_in        = fne_ff;
      rne_in        = rne_ff;
      total_in      = total_ff;
      top_v_in      = top_v_ff;
      top_e_in      = top_e_ff;
      top_t_in      = top_t_ff;
      top_p_in      = top_p_ff;
      pv_in         = pv_ff;
      add_from_in   = add_from_ff;
      add_to_in     = add_to_ff;
      add_ok_in     = add_ok_ff;
      held_valid_in = held_valid_ff;
      held_v_in     = held_v_ff;
      held_c_in     = held_c_ff;
      stk_we        = 1'b0;
      fin_we        = 1'b0;
      emit          = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req.func)
                  FUNC_CLEAR: begin
                     fne_in   = '0;
                     rne_in   = '0;
                     total_in = '0;
                  end
                  FUNC_ADD: begin
                     add_from_in = req.edge_from;
                     add_to_in   = req.edge_to;
                     add_ok_in   = ({1'b0, req.edge_from} < n_act) &&
                                   ({1'b0, req.edge_to} < n_act) &&
                                   (total_ff < ECW'(MAX_EDGES));
                     state_in    = S_ADD;
                  end
                  FUNC_COMPUTE: begin
                     visited_in    = '0;
                     pass_in       = 1'b0;
                     scan_in       = '0;
                     fin_in        = '0;
                     sp_in         = '0;
                     comp_in       = '0;
                     held_valid_in = 1'b0;
                     state_in      = S_SCAN1;
                  end
                  default: ;
               endcase
            end
         end
         S_ADD: begin
            if (add_ok_ff) begin
               fne_in[add_from_ff[VAW-1:0]] = 1'b1;
               rne_in[add_to_ff[VAW-1:0]]   = 1'b1;
               total_in = total_ff + ECW'(1);
            end
            state_in = S_IDLE;
         end
         S_SCAN1: begin
            if (scan_ff == n_act) begin
               // forward pass over, start the transposed pass
               pass_in    = 1'b1;
               visited_in = '0;
               scan_in    = COUNT_W'(fin_ff);
               state_in   = S_SCAN2;
            end else if (visited_ff[scan_ff[VAW-1:0]]) begin
               scan_in = scan_ff + COUNT_W'(1);
            end else begin
               pv_in    = scan_ff[VERTEX_W-1:0];
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!(pass_ff && held_valid_ff && !out_free)) begin
               visited_in[pv_ff[VAW-1:0]] = 1'b1;
               stk_we   = (sp_ff != '0);
               top_v_in = pv_ff;
               top_e_in = head_rd;
               top_t_in = tail_rd;
               top_p_in = ne_sel[pv_ff[VAW-1:0]];
               sp_in    = sp_ff + SPW'(1);
               if (pass_ff) begin
                  // release the previous result now that its successor is known
                  emit.push                     = held_valid_ff;
                  emit.result.vertex            = held_v_ff;
                  emit.result.component_index   = held_c_ff[VERTEX_W-1:0];
                  emit.result.last_of_component = (held_c_ff != comp_ff);
                  emit.result.last              = 1'b0;
                  held_valid_in = 1'b1;
                  held_v_in     = pv_ff;
                  held_c_in     = comp_ff;
               end
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (sp_ff == '0) begin
               if (pass_ff) begin
                  comp_in  = comp_ff + COUNT_W'(1);
                  state_in = S_SCAN2;
               end else begin
                  scan_in  = scan_ff + COUNT_W'(1);
                  state_in = S_SCAN1;
               end
            end else if (top_p_ff) begin
               state_in = S_EDGE;
            end else begin
               fin_we = !pass_ff;
               if (!pass_ff) begin
                  fin_in = fin_ff + SPW'(1);
               end
               sp_in = sp_ff - SPW'(1);
               state_in = (sp_ff > SPW'(1)) ? S_POP : S_STEP;
            end
         end
         S_EDGE: begin
            if (top_e_ff == top_t_ff) begin
               top_p_in = 1'b0;
            end else begin
               top_e_in = nxt_rd;
            end
            if (({1'b0, far_rd} < n_act) && !visited_ff[far_rd[VAW-1:0]] &&
                (sp_ff < SPW'(MAX_VERTICES))) begin
               pv_in    = far_rd;
               state_in = S_PUSH;
            end else begin
               state_in = S_STEP;
            end
         end
         S_POP: begin
            {top_v_in, top_e_in, top_t_in, top_p_in} = stk_rd;
            state_in = S_STEP;
         end
         S_SCAN2: begin
            if (scan_ff == '0) begin
               if (!held_valid_ff) begin
                  state_in = S_IDLE;
               end else if (out_free) begin
                  emit.push                     = 1'b1;
                  emit.result.vertex            = held_v_ff;
                  emit.result.component_index   = held_c_ff[VERTEX_W-1:0];
                  emit.result.last_of_component = 1'b1;
                  emit.result.last              = 1'b1;
                  held_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end else begin
               scan_in  = scan_ff - COUNT_W'(1);
               state_in = S_SCAN2R;
            end
         end
         S_SCAN2R: begin
            if (visited_ff[fin_rd[VAW-1:0]]) begin
               state_in = S_SCAN2;
            end else begin
               pv_in    = fin_rd;
               state_in = S_PUSH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign idle = (state_ff == S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pass_ff       <= 1'b0;
         fne_ff        <= '0;
         rne_ff        <= '0;
         total_ff      <= '0;
         sp_ff         <= '0;
         fin_ff        <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         fne_ff        <= fne_in;
         rne_ff        <= rne_in;
         total_ff      <= total_in;
         sp_ff         <= sp_in;
         fin_ff        <= fin_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      comp_ff     <= comp_in;
      visited_ff  <= visited_in;
      top_v_ff    <= top_v_in;
      top_e_ff    <= top_e_in;
      top_t_ff    <= top_t_in;
      top_p_ff    <= top_p_in;
      pv_ff       <= pv_in;
      add_from_ff <= add_from_in;
      add_to_ff   <= add_to_in;
      add_ok_ff   <= add_ok_in;
      held_v_ff   <= held_v_in;
      held_c_ff   <= held_c_in;
   end

   // per-edge stores
   scc_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_EDGES)) u_esrc (
      .clock(clock), .wr_en(add_wr), .wr_addr(edge_idx), .wr_data(add_from_ff),
      .rd_addr(top_e_ff), .rd_data(esrc_rd));

   scc_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_EDGES)) u_etgt (
      .clock(clock), .wr_en(add_wr), .wr_addr(edge_idx), .wr_data(add_to_ff),
      .rd_addr(top_e_ff), .rd_data(etgt_rd));

   scc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_fnext (
      .clock(clock), .wr_en(fnext_we), .wr_addr(ftail_rd), .wr_data(edge_idx),
      .rd_addr(top_e_ff), .rd_data(fnext_rd));

   scc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_rnext (
      .clock(clock), .wr_en(rnext_we), .wr_addr(rtail_rd), .wr_data(edge_idx),
      .rd_addr(top_e_ff), .rd_data(rnext_rd));

   // per-vertex list heads and tails
   scc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_fhead (
      .clock(clock), .wr_en(fhead_we), .wr_addr(add_from_ff[VAW-1:0]),
      .wr_data(edge_idx), .rd_addr(walk_v[VAW-1:0]), .rd_data(fhead_rd));

   scc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_rhead (
      .clock(clock), .wr_en(rhead_we), .wr_addr(add_to_ff[VAW-1:0]),
      .wr_data(edge_idx), .rd_addr(walk_v[VAW-1:0]), .rd_data(rhead_rd));

   scc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_ftail (
      .clock(clock), .wr_en(add_wr), .wr_addr(add_from_ff[VAW-1:0]),
      .wr_data(edge_idx), .rd_addr(ftail_ra), .rd_data(ftail_rd));

   scc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_rtail (
      .clock(clock), .wr_en(add_wr), .wr_addr(add_to_ff[VAW-1:0]),
      .wr_data(edge_idx), .rd_addr(rtail_ra), .rd_data(rtail_rd));

   // walk stack below the top entry
   scc_ram #(.WIDTH(SEW), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));

   // forward finish order
   scc_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_finish (
      .clock(clock), .wr_en(fin_we), .wr_addr(fin_ff[VAW-1:0]), .wr_data(top_v_ff),
      .rd_addr(fin_ra), .rd_data(fin_rd));

   `ASSERT_NEVER(a_push_blocked, emit.push && !out_free, "result pushed into a full output stage")
   `ASSERT_CLK(a_push_pass, emit.push |-> pass_ff, "result produced outside the transposed pass")
   `ASSERT_CLK(a_stack_bound, sp_ff <= SPW'(MAX_VERTICES), "walk stack overflow")

endmodule

`default_nettype wire

// ----- rtl/core/strongly_connected_components_unit.sv -----
// Strongly connected components unit (Kosaraju). A clear transaction is done
// in the idle state; an add-edge transaction fetches the list tail, then appends
// the edge to the lists. A compute transaction runs two depth-first passes on
// one small sequencer with a stack memory; every store is a RAM with one write
// port and a registered read port. Output stalls hold the transposed pass, which
// gives one result per vertex. The input side is not ready while a transaction
// is in progress.
// ----------------------------------------------------------------------------
// strongly_connected_components_unit
// Top level: configuration register, output stage and the graph sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module strongly_connected_components_unit
   import scc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data
);

   logic [COUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               core_idle, out_free;
   emit_type           emit;

   // vertex count register
   assign csr_ready       = 1'b1;
   assign vertex_count_in = (csr_valid && csr_ready) ? csr_data : vertex_count_ff;

   // output stage
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = emit.push || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = emit.push ? emit.result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_ready = core_idle;

   scc_core #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (req_valid && req_ready),
      .req          (req_data),
      .vertex_count (vertex_count_ff),
      .out_free     (out_free),
      .idle         (core_idle),
      .emit         (emit)
   );

endmodule

`default_nettype wire

// ----- sim/strongly_connected_components_unit_tb.sv -----
// ----------------------------------------------------------------------------
// strongly_connected_components_unit_tb
// Self-checking bench: loads random graphs edge by edge, runs compute
// transactions and compares every reported vertex against a local Kosaraju
// model, across several vertex counts with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

// tracks the graph and holds the vertex reports still to come
class scc_scoreboard;
   localparam int NV = 64;
   localparam int NE = 512;

   bit [6:0]    vcount;
   bit [5:0]    src[NE];
   bit [5:0]    dst[NE];
   int          fwd_list[NV][$];
   int          rev_list[NV][$];
   int          edge_cnt;
   scc_pkg::rsp_type pending[$];
   int          errors;
   int          reports_seen;

   function new();
      vcount = scc_pkg::VERTEX_COUNT_RESET;
      clear_graph();
      errors = 0;
      reports_seen = 0;
   endfunction

   function void clear_graph();
      for (int v = 0; v < NV; v++) begin
         fwd_list[v].delete();
         rev_list[v].delete();
      end
      edge_cnt = 0;
   endfunction

   function int active_n();
      return (vcount < NV) ? int'(vcount) : NV;
   endfunction

   // one depth-first walk; forward records finish order, reverse queues reports
   function void walk(int start, bit fwd, int n, ref bit seen[NV], ref int order[$],
                      input int comp);
      int stk_v[$];
      int stk_i[$];
      int t, v, e, w;
      scc_pkg::rsp_type r;
      seen[start] = 1;
      stk_v = {stk_v, start};
      stk_i = {stk_i, 0};
      if (!fwd) begin
         r = '0; r.vertex = 6'(start); r.component_index = 6'(comp);
         pending = {pending, r};
      end
      while (stk_v.size() > 0) begin
         t = stk_v.size() - 1;
         v = stk_v[t];
         if (fwd ? (stk_i[t] < fwd_list[v].size()) : (stk_i[t] < rev_list[v].size())) begin
            e = fwd ? fwd_list[v][stk_i[t]] : rev_list[v][stk_i[t]];
            stk_i[t]++;
            w = fwd ? int'(dst[e]) : int'(src[e]);
            if (w < n && !seen[w] && stk_v.size() < NV) begin
               seen[w] = 1;
               stk_v = {stk_v, w};
               stk_i = {stk_i, 0};
               if (!fwd) begin
                  r = '0; r.vertex = 6'(w); r.component_index = 6'(comp);
                  pending = {pending, r};
               end
            end
         end else begin
            void'(stk_v.pop_back());
            void'(stk_i.pop_back());
            if (fwd) order = {order, v};
         end
      end
   endfunction

   function void note_request(scc_pkg::req_type q);
      int n;
      bit seen[NV];
      int order[$];
      int comp;
      int first;
      n = active_n();
      case (q.func)
         scc_pkg::FUNC_CLEAR: clear_graph();
         scc_pkg::FUNC_ADD: begin
            if (q.edge_from < n && q.edge_to < n && edge_cnt < NE) begin
               src[edge_cnt] = q.edge_from;
               dst[edge_cnt] = q.edge_to;
               fwd_list[q.edge_from] = {fwd_list[q.edge_from], edge_cnt};
               rev_list[q.edge_to] = {rev_list[q.edge_to], edge_cnt};
               edge_cnt++;
            end
         end
         scc_pkg::FUNC_COMPUTE: begin
            first = pending.size();
            foreach (seen[i]) seen[i] = 0;
            for (int i = 0; i < n; i++)
               if (!seen[i]) walk(i, 1, n, seen, order, 0);
            foreach (seen[i]) seen[i] = 0;
            comp = 0;
            for (int i = order.size() - 1; i >= 0; i--) begin
               if (!seen[order[i]]) begin
                  walk(order[i], 0, n, seen, order, comp);
                  pending[pending.size()-1].last_of_component = 1;
                  comp++;
               end
            end
            if (pending.size() > first) pending[pending.size()-1].last = 1;
         end
         default: ;
      endcase
   endfunction

   function void check_report(scc_pkg::rsp_type got);
      scc_pkg::rsp_type exp;
      reports_seen++;
      if (pending.size() == 0) begin
         $error("unexpected result vertex=%0d", got.vertex);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.vertex !== exp.vertex) begin
         $error("vertex exp %0d got %0d", exp.vertex, got.vertex); errors++;
      end
      if (got.component_index !== exp.component_index) begin
         $error("component_index exp %0d got %0d", exp.component_index,
                got.component_index); errors++;
      end
      if (got.last_of_component !== exp.last_of_component) begin
         $error("last_of_component exp %0d got %0d", exp.last_of_component,
                got.last_of_component); errors++;
      end
      if (got.last !== exp.last) begin
         $error("last exp %0d got %0d", exp.last, got.last); errors++;
      end
   endfunction
endclass

module strongly_connected_components_unit_tb;
   import scc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 200000;

   // operation code the block ignores
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_type      req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_type      rsp_data;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [6:0]   csr_data = '0;

   scc_scoreboard board = new();
   int           idle_cycles = 0;
   int           computes = 0;
   bit           stall_enable = 1;

   always #2 clock = ~clock;

   strongly_connected_components_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
   endfunction

   // result side: random stalls while enabled, check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_report(rsp_data);
   end
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (!stall_enable) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 15) == 0);
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout waiting for a transaction");
         $display("end of test: mismatches");
         $finish;
      end
   end

   // valid stays high into the next transaction when there is no gap
   task automatic send(logic [1:0] f, logic [5:0] a, logic [5:0] b);
      req_type q;
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      q.func = f; q.edge_from = a; q.edge_to = b;
      req_data <= q;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      board.note_request(q);
      if (f == FUNC_COMPUTE) computes++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_count(logic [6:0] v);
      drain();
      csr_data <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      board.vcount = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // random graph load and compute on the current vertex count
   task automatic random_graph(int edges);
      int n;
      n = board.active_n();
      send(FUNC_CLEAR, 6'($urandom), 6'($urandom));
      for (int i = 0; i < edges; i++) begin
         if ($urandom_range(0, 9) == 0) send(FUNC_SPARE, 6'($urandom), 6'($urandom));
         else if ($urandom_range(0, 9) == 0) send(FUNC_ADD, 6'($urandom), 6'($urandom));
         else send(FUNC_ADD, 6'($urandom_range(0, n > 0 ? n - 1 : 0)),
                   6'($urandom_range(0, n > 0 ? n - 1 : 0)));
      end
      send(FUNC_COMPUTE, 6'($urandom), 6'($urandom));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty graph at full size, extremes, cycle, unused code
      send(FUNC_COMPUTE, 6'd0, 6'd0);
      send(FUNC_ADD, 6'd63, 6'd0);
      send(FUNC_ADD, 6'd0, 6'd63);
      send(FUNC_ADD, 6'd63, 6'd63);
      send(FUNC_SPARE, 6'h3f, 6'h3f);
      send(FUNC_COMPUTE, 6'h3f, 6'h3f);
      write_count(7'd4);
      send(FUNC_CLEAR, 6'd0, 6'd0);
      send(FUNC_ADD, 6'd0, 6'd1);
      send(FUNC_ADD, 6'd1, 6'd2);
      send(FUNC_ADD, 6'd2, 6'd0);
      send(FUNC_ADD, 6'd2, 6'd3);
      send(FUNC_ADD, 6'd3, 6'd5);
      send(FUNC_COMPUTE, 6'd0, 6'd0);
      // count lowered after load: neighbors above it are skipped
      write_count(7'd2);
      send(FUNC_COMPUTE, 6'd0, 6'd0);
      write_count(7'd0);
      send(FUNC_ADD, 6'd0, 6'd0);
      send(FUNC_COMPUTE, 6'd0, 6'd0);
      write_count(7'd127);
      send(FUNC_COMPUTE, 6'd0, 6'd0);
      write_count(7'd1);
      send(FUNC_ADD, 6'd0, 6'd0);
      send(FUNC_COMPUTE, 6'd0, 6'd0);

      // random: mostly small graphs, a couple at full size
      for (int p = 0; p < 12; p++) begin
         if (p == 6) stall_enable = 0;
         if (p == 8) stall_enable = 1;
         write_count((p % 5 == 4) ? 7'd64 : 7'($urandom_range(1, 12)));
         random_graph($urandom_range(4, 14));
         if (p % 4 == 0) drain();
      end

      drain();
      $display("covered %0d compute runs and %0d vertex reports over several vertex counts",
               computes, board.reports_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/scc_ram.sv
rtl/core/scc_core.sv
rtl/core/strongly_connected_components_unit.sv
sim/strongly_connected_components_unit_tb.sv
